// ----- src/grcf_pkg.sv -----
// Shared constants, payload types and sequencer states for the rectangle fill unit.
`timescale 1ns / 1ps
package grcf_pkg;

	// Frame store size in pixels.
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(DEPTH);

	// A far edge is an 8-bit origin plus a 9-bit span, so it needs 10 bits.
	localparam int FAR_W   = 10;
	localparam int LIM_W   = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
		$clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
	localparam int EXT_W   = (LIM_W > FAR_W) ? LIM_W : FAR_W;

	localparam logic [23:0] WHITE_PIXEL = 24'hFF_FFFF;

	// Operation codes.
	localparam logic OP_PAINT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] left;
		logic [7:0] top;
		logic [8:0] span_x;
		logic [8:0] span_y;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} cmd_item_t;

	typedef struct packed {
		logic [8:0] canvas_width;
		logic [8:0] canvas_height;
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
		logic       clipped;
	} rsp_item_t;

	// Geometry of one item, worked out when it is accepted.
	typedef struct packed {
		logic [EXT_W-1:0]  end_x;
		logic [EXT_W-1:0]  end_y;
		logic              clip;
		logic              empty;
		logic              inb;
		logic [ADDR_W-1:0] start_addr;
		logic [EXT_W-1:0]  new_w;
		logic [EXT_W-1:0]  new_h;
	} geom_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PAINT,
		ST_READ,
		ST_FINISH
	} state_t;

endpackage

// ----- src/growing_canvas_rectangle_fill_unit.sv -----
// Top level of the rectangle fill unit: sequencer, frame memory and result register.
`timescale 1ns / 1ps
// After reset the unit sweeps the frame memory to white, one pixel per cycle, over all
// MAX_WIDTH * MAX_HEIGHT locations (65536 at 256 by 256) and holds cmd_stall high until done.
// A paint then is accepted in ST_IDLE, writes one visible pixel of the clipped rectangle
// per cycle in ST_PAINT and loads its result in ST_FINISH; a read goes through ST_READ, and
// a paint that covers no pixel goes straight to ST_FINISH. The single write port of the
// frame memory and the one address adder that steps through it set this pace. One item is in
// work at a time, and a finished result waits in the output register until it is taken.
module growing_canvas_rectangle_fill_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  grcf_pkg::cmd_item_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output grcf_pkg::rsp_item_t rsp
);
	import grcf_pkg::*;

	state_t            state_q, state_d;
	geom_t             geom;
	logic [EXT_W-1:0]  ext_w_q, ext_h_q;
	logic [EXT_W-1:0]  col_q, row_q, left_q, end_x_q, end_y_q;
	logic [ADDR_W-1:0] addr_q, row_base_q, addr_next;
	logic [23:0]       colour_q, rd_data_q, wr_data;
	logic              op_q, clip_q, inb_q;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;
	logic              accept, load_rsp, mem_we, last_col, last_row, wrap;
	logic [23:0]       mem [DEPTH];

	grcf_geom u_geom (
		.cmd   (cmd),
		.ext_w (ext_w_q),
		.ext_h (ext_h_q),
		.geom  (geom)
	);

	// Shared address adder: next pixel, next row, or next clearing location.
	always_comb begin
		last_col  = (col_q + EXT_W'(1)) == end_x_q;
		last_row  = (row_q + EXT_W'(1)) == end_y_q;
		wrap      = (state_q == ST_PAINT) && last_col;
		addr_next = (wrap ? row_base_q : addr_q) +
			(wrap ? ADDR_W'(MAX_WIDTH) : ADDR_W'(1));
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control.
	always_comb begin
		state_d   = state_q;
		cmd_stall = (state_q != ST_IDLE);
		accept    = cmd_valid && (state_q == ST_IDLE);
		load_rsp  = (state_q == ST_FINISH) && (!rsp_valid_q || !rsp_stall);
		mem_we    = 1'b0;
		wr_data   = colour_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we  = 1'b1;
				wr_data = WHITE_PIXEL;
				if (addr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (cmd.op == OP_READ) begin
						state_d = ST_READ;
					end else if (geom.empty) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_PAINT;
					end
				end
			end
			ST_PAINT: begin
				mem_we = 1'b1;
				if (last_col && last_row) begin
					state_d = ST_FINISH;
				end
			end
			ST_READ: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (load_rsp) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Frame memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= wr_data;
		end
		rd_data_q <= mem[addr_q];
	end

	// Address counter and canvas extent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			ext_w_q <= EXT_W'(1);
			ext_h_q <= EXT_W'(1);
		end else begin
			if (accept) begin
				addr_q <= geom.start_addr;
				if (cmd.op == OP_PAINT) begin
					ext_w_q <= geom.new_w;
					ext_h_q <= geom.new_h;
				end
			end else if (state_q == ST_CLEAR || state_q == ST_PAINT) begin
				addr_q <= addr_next;
			end
		end
	end

	// Item registers and rectangle scan counters.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= cmd.op;
			colour_q   <= {cmd.red, cmd.green, cmd.blue};
			left_q     <= EXT_W'(cmd.left);
			col_q      <= EXT_W'(cmd.left);
			row_q      <= EXT_W'(cmd.top);
			end_x_q    <= geom.end_x;
			end_y_q    <= geom.end_y;
			clip_q     <= geom.clip;
			inb_q      <= geom.inb;
			row_base_q <= geom.start_addr;
		end else if (state_q == ST_PAINT) begin
			if (last_col) begin
				col_q      <= left_q;
				row_q      <= row_q + EXT_W'(1);
				row_base_q <= addr_next;
			end else begin
				col_q <= col_q + EXT_W'(1);
			end
		end
	end

	// Result register: holds a transfer until the far side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.canvas_width  <= ext_w_q[8:0];
			rsp_q.canvas_height <= ext_h_q[8:0];
			if (op_q == OP_READ) begin
				{rsp_q.pixel_red, rsp_q.pixel_green, rsp_q.pixel_blue} <=
					inb_q ? rd_data_q : WHITE_PIXEL;
				rsp_q.clipped <= 1'b0;
			end else begin
				{rsp_q.pixel_red, rsp_q.pixel_green, rsp_q.pixel_blue} <= 24'd0;
				rsp_q.clipped <= clip_q;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The extent never shrinks.
	a_ext_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (ext_w_q >= $past(ext_w_q)) && (ext_h_q >= $past(ext_h_q)))
		else $error("canvas extent shrank");

	// The extent stays inside the frame store and is never zero.
	a_ext_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(ext_w_q >= EXT_W'(1)) && (ext_w_q <= EXT_W'(MAX_WIDTH)) &&
		(ext_h_q >= EXT_W'(1)) && (ext_h_q <= EXT_W'(MAX_HEIGHT)))
		else $error("canvas extent out of range");

	// Paint writes stay inside the clipped rectangle.
	a_paint_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAINT) |-> (col_q < end_x_q) && (row_q < end_y_q))
		else $error("paint write outside rectangle");

	// A finished result is never loaded over one still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !load_rsp)
		else $error("pending result overwritten");

endmodule

// ----- src/grcf_geom.sv -----
// Clipping, extent growth and start address for an incoming item.
`timescale 1ns / 1ps
module grcf_geom (
	input  grcf_pkg::cmd_item_t            cmd,
	input  logic [grcf_pkg::EXT_W-1:0]     ext_w,
	input  logic [grcf_pkg::EXT_W-1:0]     ext_h,
	output grcf_pkg::geom_t                geom
);
	import grcf_pkg::*;

	logic [EXT_W-1:0] left_e;
	logic [EXT_W-1:0] top_e;
	logic [EXT_W-1:0] far_x;
	logic [EXT_W-1:0] far_y;
	logic [EXT_W-1:0] end_x;
	logic [EXT_W-1:0] end_y;
	logic             over_x;
	logic             over_y;

	// Far edges, clamped to the frame store.
	always_comb begin
		left_e = EXT_W'(cmd.left);
		top_e  = EXT_W'(cmd.top);
		far_x  = left_e + EXT_W'(cmd.span_x);
		far_y  = top_e + EXT_W'(cmd.span_y);
		over_x = far_x > EXT_W'(MAX_WIDTH);
		over_y = far_y > EXT_W'(MAX_HEIGHT);
		end_x  = over_x ? EXT_W'(MAX_WIDTH) : far_x;
		end_y  = over_y ? EXT_W'(MAX_HEIGHT) : far_y;
	end

	// Result geometry; the start address serves both paint and read.
	always_comb begin
		geom.end_x      = end_x;
		geom.end_y      = end_y;
		geom.clip       = over_x | over_y;
		geom.empty      = (left_e >= end_x) | (top_e >= end_y);
		geom.inb        = (left_e < EXT_W'(MAX_WIDTH)) & (top_e < EXT_W'(MAX_HEIGHT));
		geom.start_addr = ADDR_W'(ADDR_W'(cmd.top) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(cmd.left);
		geom.new_w      = (end_x > ext_w) ? end_x : ext_w;
		geom.new_h      = (end_y > ext_h) ? end_y : ext_h;
	end

endmodule
